### rtl/core/cqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqd_pkg: shared types and constants for the coefficient quantizer core
// Widths, register indexes, controller states and the command bundle
// passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package cqd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Restoring divider: dividend 2|x| (+q), divisor 2q
  localparam int DIV_N_W  = SAMPLE_W + 2;   // dividend / quotient bits
  localparam int DIV_D_W  = STEP_W + 1;     // divisor bits
  localparam int DIV_STEPS = DIV_N_W;
  localparam int ITER_W   = $clog2(DIV_STEPS);

  localparam int PROD_W   = (SAMPLE_W + 2) + STEP_W;  // (2|i|+1) * q
  localparam int MAG_W    = SAMPLE_W + 1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;

  localparam logic DIR_QUANT   = 1'b0;
  localparam logic DIR_DEQUANT = 1'b1;
  localparam logic METHOD_DEADZONE = 1'b0;
  localparam logic METHOD_MIDTREAD = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture a new sample
    logic div_step;  // one restoring divide iteration
    logic mul;       // register the dequantize product
    logic finish;    // clip and write the output register
  } dp_cmd_t;

endpackage

### rtl/core/coefficient_quantizer_dequantizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coefficient_quantizer_dequantizer_core: deadzone / mid-tread quantizer
// Streams transform coefficients in and quantization indices out, or the
// reverse, under a direction, method and step size held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed 16-bit sample per transfer (coefficient or index).
//   out_* : one result per input; tdata carries the 16-bit result and the
//           running count of nonzero indices, tuser flags a clipped result or a quantize with step 0.
//   cfg_* : write-only registers 0 direction, 1 method, 2 step size; write
//           them only while the core is idle.
// Timing:
//   Quantize runs an 18-step bit-serial restoring divider and then writes the
//   output register; a new sample is taken only once the previous one has
//   reached the output register. Dequantize uses one registered multiply.
//   The core holds one sample in flight; the output register lets the next
//   sample enter while the previous result waits. If the receiver stalls,
//   the next result waits in the datapath and in_tready stays low.
// Reset: rst_n (synchronous) clears the controller, the nonzero counter and
//   the registers to direction 0, deadzone, step 16.
// ----------------------------------------------------------------------------
module coefficient_quantizer_dequantizer_core
  import cqd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // [15:0] sample_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [15:0] sample_out, [47:16] nonzero_total
  output logic [OUT_USER_W-1:0] out_tuser,   // [0] saturated
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [STEP_W-1:0]     cfg_wdata
);

  logic              direction_r;
  logic              method_r;
  logic [STEP_W-1:0] step_r;
  dp_cmd_t           cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_QUANT;
      method_r    <= METHOD_DEADZONE;
      step_r      <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION: direction_r <= cfg_wdata[0];
        CFG_METHOD:    method_r    <= cfg_wdata[0];
        CFG_STEP:      step_r      <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  cqd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .direction  (direction_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cqd_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .direction    (direction_r),
    .quant_method (method_r),
    .step_size    (step_r),
    .in_tdata     (in_tdata),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule

### rtl/core/cqd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqd_ctrl: sequencing controller
// Walks one sample through load, divide or multiply, and output write, and
// owns the handshake flags of both stream channels.
// ----------------------------------------------------------------------------
module cqd_ctrl
  import cqd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    direction,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    case (state_r)
      ST_IDLE: begin
        iter_nxt = '0;
        if (in_tvalid) begin
          state_nxt = (direction == DIR_DEQUANT) ? ST_MUL : ST_DIV;
        end
      end
      ST_DIV: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == ITER_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: cmd.load     = in_tvalid;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_DONE: cmd.finish   = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/cqd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqd_datapath: quantizer / dequantizer arithmetic
// Bit-serial restoring divider for quantizing, one registered multiply for
// dequantizing, 16-bit clipping, nonzero counter and the output register.
// ----------------------------------------------------------------------------
module cqd_datapath
  import cqd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic                  direction,
  input  logic                  quant_method,
  input  logic [STEP_W-1:0]     step_size,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] sample_in
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] sample_out, [47:16] nonzero_total
  output logic [OUT_USER_W-1:0] out_tuser   // [0] saturated
);

  localparam int WIDE_W = PROD_W + 1;

  logic                neg_r;
  logic [MAG_W-1:0]    mag_r;
  logic [DIV_N_W-1:0]  num_r;   // dividend, shifts into quotient
  logic [DIV_D_W-1:0]  den_r;
  logic [DIV_D_W-1:0]  rem_r;
  logic [PROD_W-1:0]   prod_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [SAMPLE_W-1:0] res_r;
  logic                sat_r;

  logic                in_neg;
  logic [MAG_W-1:0]    in_mag;
  logic [DIV_N_W-1:0]  num_load;

  logic [DIV_N_W-1:0]  shifted;
  logic [DIV_N_W:0]    trial;
  logic                q_bit;

  logic [DIV_N_W-1:0]  mul_a;

  logic                step_zero;
  logic [WIDE_W-1:0]   m;
  logic                m_nonzero;
  logic                res_neg;
  logic                clip;
  logic [SAMPLE_W-1:0] res_val;
  logic                sat_val;

  // Sign and magnitude of the incoming sample
  assign in_neg   = in_tdata[SAMPLE_W-1];
  assign in_mag   = in_neg ? (MAG_W'(0) - {1'b1, in_tdata[SAMPLE_W-1:0]})
                           : {1'b0, in_tdata[SAMPLE_W-1:0]};
  // deadzone: 2|x| / 2q, mid-tread: (2|x| + q) / 2q
  assign num_load = {in_mag, 1'b0} +
                    ((quant_method == METHOD_MIDTREAD) ? DIV_N_W'(step_size) : '0);

  // Restoring divide step
  assign shifted = {rem_r, num_r[DIV_N_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign q_bit   = !trial[DIV_N_W];

  // Dequantize multiplicand: deadzone (2|i|+1), mid-tread |i|
  assign mul_a = (quant_method == METHOD_MIDTREAD) ? {1'b0, mag_r} : {mag_r, 1'b1};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_neg;
      mag_r <= in_mag;
      num_r <= num_load;
      den_r <= {step_size, 1'b0};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[DIV_N_W-2:0], q_bit};
      rem_r <= q_bit ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= mul_a * step_size;
    end
  end

  // Result magnitude and clipping
  assign step_zero = (step_size == '0);

  always_comb begin
    if (direction == DIR_QUANT) begin
      if (step_zero) begin
        m = neg_r ? WIDE_W'(32768) : WIDE_W'(32767);
      end else begin
        m = WIDE_W'(num_r);
      end
    end else if (quant_method == METHOD_MIDTREAD) begin
      m = {1'b0, prod_r};
    end else if (mag_r == '0) begin
      m = '0;
    end else begin
      m = ({1'b0, prod_r} + WIDE_W'(1)) >> 1;   // round half away from zero
    end
  end

  assign m_nonzero = (m != '0);
  assign res_neg   = neg_r && m_nonzero;
  assign clip      = res_neg ? (m > WIDE_W'(32768)) : (m > WIDE_W'(32767));

  always_comb begin
    if (clip) begin
      res_val = res_neg ? 16'h8000 : 16'h7FFF;
    end else if (res_neg) begin
      res_val = SAMPLE_W'(0) - m[SAMPLE_W-1:0];
    end else begin
      res_val = m[SAMPLE_W-1:0];
    end
    sat_val = clip || ((direction == DIR_QUANT) && step_zero);
  end

  always_comb begin
    count_nxt = count_r;
    if ((direction == DIR_QUANT) && m_nonzero && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r <= res_val;
      sat_r <= sat_val;
    end
  end

  assign out_tdata = {count_r, res_r};
  assign out_tuser = sat_r;

endmodule
